// File: hdl/avor_pkg.sv
// Shared types and constants of the ADC volt/ohm readout.
`default_nettype none
package avor_pkg;

    // Fixed field widths
    localparam int SAMPLE_IN_W = 10;
    localparam int VAL_W       = 16;
    localparam int COUNT_W     = 3;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 5;
    localparam int CNT_W       = 4;
    localparam int QUO10_W     = 13;

    // Request kinds carried in the input tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TOGGLE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FULL_SCALE = 1'b0;
    localparam logic CFG_REF_OHMS   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [VAL_W-1:0] RST_FULL_SCALE = 16'd5000;
    localparam logic [VAL_W-1:0] RST_REF_OHMS   = 16'd5000;

    // Divide by ten: q = (x * RECIP10) >> RECIP10_SH, exact for 16-bit x
    localparam logic [16:0] RECIP10    = 17'd52429;
    localparam int          RECIP10_SH = 19;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       toggle;
        logic       load;
        logic       mul;
        logic       prep;
        logic       div_step;
        logic       dig_step;
        logic [2:0] dig_k;
        logic       emit;
    } t_avor_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_div;
    } t_avor_sts;

    // One finished result
    typedef struct packed {
        logic               ohm_mode;
        logic               negative;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] digit_count;
        logic [DIGIT_W-1:0] digit4;
        logic [DIGIT_W-1:0] digit3;
        logic [DIGIT_W-1:0] digit2;
        logic [DIGIT_W-1:0] digit1;
        logic [DIGIT_W-1:0] digit0;
    } t_avor_res;

endpackage
`default_nettype wire

// File: hdl/avor_ctrl.sv
// Sequencer of the readout: accepts items and steps the datapath.
`default_nettype none
module avor_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    input  wire                    i_req_type,
    output logic                   o_s_tready,
    input  wire                    i_out_free,
    input  avor_pkg::t_avor_sts    i_sts,
    output avor_pkg::t_avor_cmd    o_cmd
);
    import avor_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(VAL_W - 1);
    localparam logic [CNT_W-1:0] DIG_LAST = CNT_W'(NUM_DIGITS - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.dig_k = r_cnt[2:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_TOGGLE) begin
                        o_cmd.toggle = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.need_div ? S_DIV : S_DIG;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DIG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIG: begin
                o_cmd.dig_step = 1'b1;
                if (r_cnt == DIG_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// File: hdl/avor_dp.sv
// Datapath of the readout: mode, configuration, multiply, divide, digits.
`default_nettype none
module avor_dp #(
    parameter int ADC_BITS = 10
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  avor_pkg::t_avor_cmd                  i_cmd,
    input  wire                                  i_cfg_we,
    input  wire                                  i_cfg_index,
    input  wire  [avor_pkg::VAL_W-1:0]           i_cfg_data,
    input  wire  [avor_pkg::SAMPLE_IN_W-1:0]     i_sample,
    output avor_pkg::t_avor_sts                  o_sts,
    output avor_pkg::t_avor_res                  o_res
);
    import avor_pkg::*;

    localparam int SW      = ADC_BITS;
    localparam int EW      = (ADC_BITS > SAMPLE_IN_W) ? ADC_BITS : SAMPLE_IN_W;
    localparam int PW      = VAL_W + ADC_BITS;
    localparam int DW      = ADC_BITS + 1;
    localparam int HALF_SH = ADC_BITS - 1;
    localparam int RPW     = VAL_W + 17;

    localparam logic [DW-1:0] FULL_D  = DW'(1) << ADC_BITS;
    localparam logic [SW:0]   HALF_X  = (SW + 1)'(1) << HALF_SH;
    localparam logic [PW:0]   HALF_M1 = ((PW + 1)'(1) << HALF_SH) - (PW + 1)'(1);

    logic                   r_ohm_mode;
    logic [VAL_W-1:0]       r_full_scale;
    logic [VAL_W-1:0]       r_ref_ohms;
    logic [SW-1:0]          r_s;
    logic                   r_gt_half;
    logic [PW-1:0]          r_prod;
    logic [DW-1:0]          r_div;
    logic [DW-1:0]          r_rem;
    logic [VAL_W-1:0]       r_val;
    logic                   r_neg;
    logic [VAL_W-1:0]       r_rest;
    logic [NUM_DIGITS*DIGIT_W-1:0] r_digs;
    logic [COUNT_W-1:0]     r_count;

    logic [EW-1:0]          w_ext;
    logic [SW-1:0]          w_s;
    logic                   w_gt;
    logic [SW-1:0]          w_mul_a;
    logic [VAL_W-1:0]       w_mul_b;
    logic [PW-1:0]          w_prod;
    logic [PW:0]            w_up;
    logic [PW:0]            w_up_sh;
    logic [PW-1:0]          w_dn_sh;
    logic [VAL_W-1:0]       w_volt;
    logic [SW-1:0]          w_hi;
    logic                   w_sat;
    logic [DW:0]            w_trial;
    logic [DW:0]            w_trial_sub;
    logic                   w_ge;
    logic [VAL_W-1:0]       w_src;
    logic [RPW-1:0]         w_rp;
    logic [QUO10_W-1:0]     w_q;
    logic [VAL_W-1:0]       w_q10;
    logic [VAL_W-1:0]       w_rem16;
    logic [DIGIT_W-1:0]     w_digit;
    logic [COUNT_W-1:0]     w_count;

    // Mask the raw sample to the converter width
    assign w_ext = EW'(i_sample);
    assign w_s   = w_ext[SW-1:0];

    // Multiply stage operands
    assign w_gt    = ({1'b0, r_s} > HALF_X);
    assign w_mul_a = (!r_ohm_mode && w_gt) ? (r_s - HALF_X[SW-1:0]) : r_s;
    assign w_mul_b = r_ohm_mode ? r_ref_ohms : r_full_scale;
    assign w_prod  = PW'(w_mul_a) * PW'(w_mul_b);

    // Voltmeter scaling: floor below half scale, ceiling above it
    assign w_up    = (PW + 1)'(r_prod) + HALF_M1;
    assign w_up_sh = w_up >> HALF_SH;
    assign w_dn_sh = r_prod >> HALF_SH;
    assign w_volt  = r_gt_half ? (r_full_scale - w_up_sh[VAL_W-1:0])
                               : w_dn_sh[VAL_W-1:0];

    // Ohmmeter saturation: quotient exceeds 16 bits when the high part reaches the divisor
    assign w_hi      = r_prod[PW-1:VAL_W];
    assign w_sat     = (DW'(w_hi) >= r_div);
    assign o_sts.need_div = r_ohm_mode && !w_sat;

    // Restoring divide step, one quotient bit per cycle
    assign w_trial     = {r_rem, r_val[VAL_W-1]};
    assign w_ge        = (w_trial >= (DW + 1)'(r_div));
    assign w_trial_sub = w_trial - (DW + 1)'(r_div);

    // Decimal digit step: divide by ten through a reciprocal
    assign w_src   = (i_cmd.dig_k == 3'd0) ? r_val : r_rest;
    assign w_rp    = RPW'(w_src) * RPW'(RECIP10);
    assign w_q     = w_rp[RECIP10_SH +: QUO10_W];
    assign w_q10   = (VAL_W'(w_q) << 3) + (VAL_W'(w_q) << 1);
    assign w_rem16 = w_src - w_q10;
    assign w_digit = w_rem16[DIGIT_W-1:0];

    always_comb begin
        if (w_digit != '0) begin
            w_count = COUNT_W'(i_cmd.dig_k) + COUNT_W'(1);
        end else if (i_cmd.dig_k == 3'd0) begin
            w_count = COUNT_W'(1);
        end else begin
            w_count = r_count;
        end
    end

    // Mode flag and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ohm_mode   <= 1'b0;
            r_full_scale <= RST_FULL_SCALE;
            r_ref_ohms   <= RST_REF_OHMS;
        end else begin
            if (i_cmd.toggle) begin
                r_ohm_mode <= ~r_ohm_mode;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                    CFG_REF_OHMS:   r_ref_ohms   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Working registers of one item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= w_s;
        end
        if (i_cmd.mul) begin
            r_prod    <= w_prod;
            r_gt_half <= w_gt;
            r_div     <= FULL_D - DW'(r_s);
        end
        if (i_cmd.prep) begin
            r_neg <= !r_ohm_mode && r_gt_half;
            r_rem <= DW'(w_hi);
            if (!r_ohm_mode) begin
                r_val <= w_volt;
            end else if (w_sat) begin
                r_val <= '1;
            end else begin
                r_val <= r_prod[VAL_W-1:0];
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_trial_sub[DW-1:0] : w_trial[DW-1:0];
            r_val <= {r_val[VAL_W-2:0], w_ge};
        end
        if (i_cmd.dig_step) begin
            r_rest  <= VAL_W'(w_q);
            r_digs  <= {w_digit, r_digs[NUM_DIGITS*DIGIT_W-1:DIGIT_W]};
            r_count <= w_count;
        end
    end

    // Present the finished result
    assign o_res.ohm_mode    = r_ohm_mode;
    assign o_res.negative    = r_neg;
    assign o_res.value       = r_val;
    assign o_res.digit_count = r_count;
    assign o_res.digit4      = r_digs[4*DIGIT_W +: DIGIT_W];
    assign o_res.digit3      = r_digs[3*DIGIT_W +: DIGIT_W];
    assign o_res.digit2      = r_digs[2*DIGIT_W +: DIGIT_W];
    assign o_res.digit1      = r_digs[1*DIGIT_W +: DIGIT_W];
    assign o_res.digit0      = r_digs[0 +: DIGIT_W];

endmodule
`default_nettype wire

// File: hdl/adc_volt_ohm_readout.sv
// Top level of the ADC volt/ohm readout with its output register.
//
// Each sample item yields one result; a toggle item flips between voltmeter
// and ohmmeter mode and yields nothing. A voltmeter sample passes through
// one multiply, one scaling step, five decimal digit steps of a shared
// divide-by-ten unit and one hand-off step into the result register; an
// ohmmeter sample adds restoring divide steps, one per bit of its 16-bit
// quotient, unless the reading saturates at 65535. The hand-off waits
// while the output register still holds an untaken result. The block
// works on one sample at a time; the next item is taken as soon as the
// result has moved to the output register, even if that result is still
// waiting downstream.
// Configuration writes are taken every cycle and must only occur while idle.
`default_nettype none
module adc_volt_ohm_readout #(
    parameter int ADC_BITS = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input items
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [9:0] adc_sample, [15:10] zero
    input  wire  [0:0]  i_s_tuser,   // [0] req_type
    // Result items
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] value, [18:16] digit_count,
                                     // [22:19] digit4, [26:23] digit3,
                                     // [30:27] digit2, [34:31] digit1,
                                     // [38:35] digit0, [39] zero
    output logic [1:0]  o_m_tuser,   // [0] in_ohm_mode, [1] negative
    // Configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import avor_pkg::*;

    t_avor_cmd  w_cmd;
    t_avor_sts  w_sts;
    t_avor_res  w_res;
    logic       w_out_free;

    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic [1:0]  r_out_user;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_m_tready;

    avor_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req_type (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    avor_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_s_tdata[SAMPLE_IN_W-1:0]),
        .o_sts       (w_sts),
        .o_res       (w_res)
    );

    // Output register valid: set on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_data <= {1'b0, w_res.digit0, w_res.digit1, w_res.digit2,
                           w_res.digit3, w_res.digit4, w_res.digit_count,
                           w_res.value};
            r_out_user <= {w_res.negative, w_res.ohm_mode};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
`default_nettype wire

// File: hdl/avor_chk.sv
// Port-level checks of the readout, bound to the top level.
`default_nettype none
module avor_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire [0:0]  i_s_tuser,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [39:0] o_m_tdata,
    input wire [1:0]  o_m_tuser
);
    import avor_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed or dropped");

    // Stop taking items while a sample is in work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser[0] == REQ_SAMPLE)) |=> !o_s_tready)
        else $error("item accepted while a sample is in work");

    // Never flag a minus sign on an ohm reading
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("negative flag in ohm mode");

    // Zero shows one digit
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[15:0] == 16'd0)) |-> (o_m_tdata[18:16] == 3'd1))
        else $error("zero value with wrong digit count");

endmodule

bind adc_volt_ohm_readout avor_chk u_avor_chk (.*);
`default_nettype wire
